### hw/rtl/mrpf_pkg.sv
`default_nettype none

package mrpf_pkg;

	// field widths of the two channels
	localparam int CMD_W  = 1;
	localparam int ROW_W  = 6;
	localparam int BCOL_W = 4;
	localparam int BYTE_W = 8;
	localparam int PAGE_W = 3;
	localparam int COL_W  = 7;
	localparam int LANE_W = 3;
	localparam int LANES  = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

	// entries of the front to back queue
	localparam int QUEUE_DEPTH = 2;

	// one classified item as it travels from front to back
	typedef struct packed {
		logic              is_read;
		logic              oob;
		logic [PAGE_W-1:0] page;
		logic [BCOL_W-1:0] bcol;
		logic [LANE_W-1:0] lane;
		logic [LANES-1:0]  lane_en;
		logic [LANE_W-1:0] bit_sel;
		logic [LANES-1:0]  wr_bits;
	} mrpf_op_t;

endpackage

`default_nettype wire

### hw/rtl/mrpf_if.sv
`default_nettype none

// request channel: raster byte writes and page byte reads
interface mrpf_req_if;
	import mrpf_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ROW_W-1:0]  pixel_row;
	logic [BCOL_W-1:0] byte_column;
	logic [BYTE_W-1:0] source_byte;
	logic [BYTE_W-1:0] pixel_mask;
	logic [PAGE_W-1:0] read_page;
	logic [COL_W-1:0]  read_column;

	modport source (
		output valid, cmd, pixel_row, byte_column, source_byte, pixel_mask,
			read_page, read_column,
		input  ready
	);
	modport sink (
		input  valid, cmd, pixel_row, byte_column, source_byte, pixel_mask,
			read_page, read_column,
		output ready
	);
endinterface

// response channel: one page byte per read
interface mrpf_rsp_if;
	import mrpf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] page_byte;

	modport source (output valid, page_byte, input ready);
	modport sink (input valid, page_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/mrpf_ram.sv
`default_nettype none

module mrpf_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mrpf_front.sv
`default_nettype none

module mrpf_front #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	mrpf_req_if.sink              req,
	input  wire logic             clearing,
	input  wire logic             q_full,
	output logic                  push,
	output mrpf_pkg::mrpf_op_t    push_op
);
	import mrpf_pkg::*;

	localparam int PAGES = (HEIGHT + 7) / 8;

	logic             row_ok;
	logic             rd_ok;
	logic [COL_W-1:0] lane_col [LANES];

	// take an item whenever the queue has room and the store is not being cleared
	assign req.ready = !q_full && !clearing;
	assign push      = req.valid && req.ready;

	assign row_ok = {2'b00, req.pixel_row} < 8'(HEIGHT);
	assign rd_ok  = ({2'b00, req.read_page} < 5'(PAGES))
		&& ({2'b00, req.read_column} < 9'(WIDTH));

	// classify the item and work out per lane enables
	always_comb begin
		push_op = '0;
		for (int i = 0; i < LANES; i++) begin
			lane_col[i] = {req.byte_column, LANE_W'(i)};
		end
		unique case (req.cmd)
			CMD_READ: begin
				push_op.is_read = 1'b1;
				push_op.oob     = !rd_ok;
				push_op.page    = req.read_page;
				push_op.bcol    = req.read_column[COL_W-1:LANE_W];
				push_op.lane    = req.read_column[LANE_W-1:0];
			end
			CMD_WRITE: begin
				push_op.page    = req.pixel_row[ROW_W-1:LANE_W];
				push_op.bcol    = req.byte_column;
				push_op.bit_sel = req.pixel_row[LANE_W-1:0];
				for (int i = 0; i < LANES; i++) begin
					// pixel i sits at bit 7-i; the store keeps it inverted
					push_op.lane_en[i] = req.pixel_mask[i] && row_ok
						&& ({2'b00, lane_col[i]} < 9'(WIDTH));
					push_op.wr_bits[i] = !req.source_byte[LANES-1-i];
				end
			end
			default: begin
				push_op = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/mrpf_queue.sv
`default_nettype none

module mrpf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mrpf_pkg::mrpf_op_t push_op,
	output logic                    full,
	input  wire logic               pop,
	output mrpf_pkg::mrpf_op_t      head_op,
	output logic                    empty
);
	import mrpf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	mrpf_op_t         ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign head_op = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

### hw/rtl/mrpf_back.sv
`default_nettype none

module mrpf_back #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mrpf_pkg::mrpf_op_t head_op,
	input  wire logic               q_empty,
	output logic                    pop,
	output logic                    clearing,
	mrpf_rsp_if.source              rsp
);
	import mrpf_pkg::*;

	localparam int PAGES  = (HEIGHT + 7) / 8;
	localparam int COLB   = (WIDTH + 7) / 8;
	localparam int DEPTH  = PAGES * COLB;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  clearing_q;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic [31:0]           addr_full;
	logic [ADDR_W-1:0]     op_addr;
	logic [ADDR_W-1:0]     ram_wr_addr;
	logic                  pop_rd;
	logic                  pop_wr;
	logic                  rd_pend_s1;
	logic                  oob_s1;
	logic [LANE_W-1:0]     lane_s1;
	logic                  move;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_data_q;
	wire  [LANES*8-1:0]    rd_flat;

	assign clearing = clearing_q;

	// row address shared by all banks
	assign addr_full   = 32'(head_op.page) * 32'(COLB) + 32'(head_op.bcol);
	assign op_addr     = addr_full[ADDR_W-1:0];
	assign ram_wr_addr = clearing_q ? clr_cnt_q : op_addr;

	// a pending read leaves for the output register when that register frees up
	assign move   = rd_pend_s1 && (!out_valid_q || rsp.ready);
	assign pop    = !q_empty && !clearing_q && (!head_op.is_read || !rd_pend_s1 || move);
	assign pop_rd = pop && head_op.is_read;
	assign pop_wr = pop && !head_op.is_read;

	// bank per column lane and per row bit: a byte write is one plain write per bank
	for (genvar b = 0; b < LANES; b++) begin : g_lane
		for (genvar k = 0; k < 8; k++) begin : g_bit
			logic we;
			assign we = clearing_q
				|| (pop_wr && head_op.lane_en[b] && (head_op.bit_sel == LANE_W'(k)));
			mrpf_ram #(
				.DATA_W(1),
				.DEPTH (DEPTH)
			) u_ram (
				.clk    (clk),
				.we     (we),
				.wr_addr(ram_wr_addr),
				.wr_data(!clearing_q && head_op.wr_bits[b]),
				.re     (pop_rd && !head_op.oob),
				.rd_addr(op_addr),
				.rd_data(rd_flat[b*8+k])
			);
		end
	end

	// clearing pass after reset, one row of all banks per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// read in flight and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_rd) begin
				rd_pend_s1 <= 1'b1;
			end else if (move) begin
				rd_pend_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_rd) begin
			oob_s1  <= head_op.oob;
			lane_s1 <= head_op.lane;
		end
		if (move) begin
			out_data_q <= oob_s1 ? '0 : rd_flat[{lane_s1, 3'b000} +: 8];
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.page_byte = out_data_q;

	a_idle_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !pop)
		else $error("item taken from queue during clearing pass");

	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		pop_rd |=> rd_pend_s1)
		else $error("read popped but not pending");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && !move) |=> (rd_pend_s1 && $stable(lane_s1) && $stable(oob_s1)))
		else $error("stalled read lost its context");

endmodule

`default_nettype wire

### hw/rtl/mono_raster_to_page_format_unit.sv
`default_nettype none

// Converts a 1 bit per pixel raster (8 horizontal pixels per byte, bit 7 leftmost)
// into OLED vertical page bytes (bit 0 top row, 0 = lit). A write transfer on req
// stores one source byte; a read transfer returns one page byte on rsp. The front
// classifies each transfer into a two-entry queue; the back retires one item per
// cycle unless a read waits on a stalled rsp, so the sustained rate is one item
// per cycle while rsp keeps up. A read result passes through the queue, the RAM
// read register and the output register on its way to rsp. The page store is
// split into 64 one-bit RAMs, one per column lane (column mod 8) and row bit
// (row mod 8), each of (HEIGHT+7)/8 * (WIDTH+7)/8 entries, so a byte write is one
// plain write per lane with no read-modify-write. After reset a clearing pass
// zeroes the whole store, during which req.ready stays low.
module mono_raster_to_page_format_unit #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mrpf_req_if.sink   req,
	mrpf_rsp_if.source rsp
);
	import mrpf_pkg::*;

	logic     clearing;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	mrpf_op_t push_op;
	mrpf_op_t head_op;

	mrpf_front #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) u_front (
		.req     (req),
		.clearing(clearing),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	mrpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (pop),
		.head_op(head_op),
		.empty  (q_empty)
	);

	mrpf_back #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_op (head_op),
		.q_empty (q_empty),
		.pop     (pop),
		.clearing(clearing),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mrpf_pkg::*;

	localparam int WIDTH       = 128;
	localparam int HEIGHT      = 64;
	localparam int PAGES       = (HEIGHT + 7) / 8;
	localparam int STORE_AW    = $clog2(PAGES * WIDTH);
	localparam int ITEMS_PHASE = 488;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 16;

	// one request as queued for the driver
	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [ROW_W-1:0]  pixel_row;
		logic [BCOL_W-1:0] byte_column;
		logic [BYTE_W-1:0] source_byte;
		logic [BYTE_W-1:0] pixel_mask;
		logic [PAGE_W-1:0] read_page;
		logic [COL_W-1:0]  read_column;
	} raster_req_t;

	logic clk;
	logic arst_n;

	mrpf_req_if req_ch ();
	mrpf_rsp_if rsp_ch ();

	mono_raster_to_page_format_unit #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the page store, page-major
	logic [BYTE_W-1:0] page_mem [0:PAGES*WIDTH-1];

	raster_req_t       pending_items [$];
	logic [BYTE_W-1:0] expected_page_bytes [$];

	bit req_busy;
	int send_idle_pct;
	int rsp_stall_pct;
	int error_count;
	int mismatch_count;
	int write_count;
	int read_count;
	int checked_count;
	int cycle_count;

	// last generated write, used to aim reads at fresh data
	logic [ROW_W-1:0]  last_row;
	logic [BCOL_W-1:0] last_bcol;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// update the shadow store for one raster byte write
	function automatic void apply_raster_write(logic [ROW_W-1:0] row, logic [BCOL_W-1:0] bcol,
		logic [BYTE_W-1:0] src, logic [BYTE_W-1:0] mask);
		int col;
		int idx;
		if (row >= HEIGHT)
			return;
		for (int i = 0; i < 8; i++) begin
			col = bcol * 8 + i;
			if (!mask[i] || col >= WIDTH)
				continue;
			idx = (row >> 3) * WIDTH + col;
			// set source pixel means lit, stored as a cleared bit
			if (src[7-i])
				page_mem[STORE_AW'(idx)][row[2:0]] = 1'b0;
			else
				page_mem[STORE_AW'(idx)][row[2:0]] = 1'b1;
		end
	endfunction

	// stored page byte, zero outside the panel
	function automatic logic [BYTE_W-1:0] page_byte_at(logic [PAGE_W-1:0] page,
		logic [COL_W-1:0] col);
		if (page >= PAGES || col >= WIDTH)
			return '0;
		return page_mem[STORE_AW'(page * WIDTH + col)];
	endfunction

	// write request with noise in the unused read fields
	function automatic raster_req_t write_item(logic [ROW_W-1:0] row, logic [BCOL_W-1:0] bcol,
		logic [BYTE_W-1:0] src, logic [BYTE_W-1:0] mask);
		raster_req_t it;
		it.cmd         = CMD_WRITE;
		it.pixel_row   = row;
		it.byte_column = bcol;
		it.source_byte = src;
		it.pixel_mask  = mask;
		it.read_page   = PAGE_W'($urandom_range(7));
		it.read_column = COL_W'($urandom_range(127));
		return it;
	endfunction

	// read request with noise in the unused write fields
	function automatic raster_req_t read_item(logic [PAGE_W-1:0] page, logic [COL_W-1:0] col);
		raster_req_t it;
		it.cmd         = CMD_READ;
		it.pixel_row   = ROW_W'($urandom_range(63));
		it.byte_column = BCOL_W'($urandom_range(15));
		it.source_byte = BYTE_W'($urandom_range(255));
		it.pixel_mask  = BYTE_W'($urandom_range(255));
		it.read_page   = page;
		it.read_column = col;
		return it;
	endfunction

	// random traffic: writes with varied masks, reads partly aimed at the last write
	function automatic raster_req_t random_item();
		logic [BYTE_W-1:0] mask;
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			last_row  = ROW_W'($urandom_range(63));
			last_bcol = BCOL_W'($urandom_range(15));
			case ($urandom_range(9)) inside
				0:       mask = 8'h00;
				[1:2]:   mask = 8'hFF;
				default: mask = BYTE_W'($urandom_range(255));
			endcase
			return write_item(last_row, last_bcol, BYTE_W'($urandom_range(255)), mask);
		end else if (sel < 80) begin
			return read_item(PAGE_W'(last_row >> 3),
				COL_W'(last_bcol * 8 + $urandom_range(7)));
		end
		return read_item(PAGE_W'($urandom_range(7)), COL_W'($urandom_range(127)));
	endfunction

	// driver: presents queued requests at the falling edge
	always @(negedge clk) begin : drive_req
		raster_req_t it;
		if (arst_n) begin
			if (!req_busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					it = pending_items.pop_front();
					req_ch.cmd         <= it.cmd;
					req_ch.pixel_row   <= it.pixel_row;
					req_ch.byte_column <= it.byte_column;
					req_ch.source_byte <= it.source_byte;
					req_ch.pixel_mask  <= it.pixel_mask;
					req_ch.read_page   <= it.read_page;
					req_ch.read_column <= it.read_column;
					req_ch.valid       <= 1'b1;
					req_busy = 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// monitor: checks response transfers, then predicts from request transfers
	always @(posedge clk) begin : watch_channels
		logic [BYTE_W-1:0] want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_page_bytes.size() == 0) begin
					error_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected page byte %02h", $realtime,
							rsp_ch.page_byte);
				end else begin
					want = expected_page_bytes.pop_front();
					checked_count++;
					if (rsp_ch.page_byte !== want) begin
						error_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: page byte mismatch, expected %02h got %02h",
								$realtime, want, rsp_ch.page_byte);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.cmd == CMD_READ) begin
					expected_page_bytes.push_back(
						page_byte_at(req_ch.read_page, req_ch.read_column));
					read_count++;
				end else begin
					apply_raster_write(req_ch.pixel_row, req_ch.byte_column,
						req_ch.source_byte, req_ch.pixel_mask);
					write_count++;
				end
				req_busy = 1'b0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[mono_raster_to_page_format_unit] ERROR");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		for (int i = 0; i < PAGES * WIDTH; i++)
			page_mem[STORE_AW'(i)] = '0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_WRITE;
		req_ch.pixel_row   = '0;
		req_ch.byte_column = '0;
		req_ch.source_byte = '0;
		req_ch.pixel_mask  = '0;
		req_ch.read_page   = '0;
		req_ch.read_column = '0;
		rsp_ch.ready       = 1'b0;
		send_idle_pct      = 0;
		rsp_stall_pct      = 0;
		last_row           = '0;
		last_bcol          = '0;
		arst_n             = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: cleared store, corners, full, empty and partial masks
		pending_items.push_back(read_item(0, 0));
		pending_items.push_back(read_item(7, 127));
		pending_items.push_back(write_item(0, 0, 8'hFF, 8'hFF));
		pending_items.push_back(read_item(0, 3));
		pending_items.push_back(write_item(0, 0, 8'h00, 8'hFF));
		pending_items.push_back(read_item(0, 0));
		pending_items.push_back(read_item(0, 7));
		pending_items.push_back(write_item(63, 15, 8'hA5, 8'hFF));
		pending_items.push_back(read_item(7, 120));
		pending_items.push_back(read_item(7, 121));
		pending_items.push_back(read_item(7, 127));
		pending_items.push_back(write_item(5, 3, 8'h0F, 8'h00));
		pending_items.push_back(read_item(0, 24));
		pending_items.push_back(write_item(9, 2, 8'h3C, 8'h81));
		pending_items.push_back(read_item(1, 16));
		pending_items.push_back(read_item(1, 17));
		pending_items.push_back(read_item(1, 23));
		pending_items.push_back(write_item(0, 0, 8'hFF, 8'h0F));
		pending_items.push_back(read_item(0, 2));
		pending_items.push_back(read_item(0, 5));
		pending_items.push_back(write_item(62, 15, 8'h00, 8'hFF));
		pending_items.push_back(read_item(7, 127));
		pending_items.push_back(write_item(7, 8, 8'h55, 8'hAA));
		pending_items.push_back(read_item(0, 65));
		pending_items.push_back(read_item(0, 64));

		// random phases: free flow, slow sender, slow receiver, both slightly slow
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
				default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
			endcase
			for (int n = 0; n < ITEMS_PHASE; n++)
				pending_items.push_back(random_item());
			while (pending_items.size() > 0 || req_busy || expected_page_bytes.size() > 0)
				@(posedge clk);
		end

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_page_bytes.size() > 0) begin
			error_count += expected_page_bytes.size();
			$display("%0d page bytes never returned", expected_page_bytes.size());
		end

		$display("covered %0d raster writes and %0d page reads, %0d page bytes checked",
			write_count, read_count, checked_count);
		$display("idle mixes: none, sender 85%%, receiver 85%%, both 13%%; %0d mismatches",
			mismatch_count);
		if (error_count == 0)
			$display("[mono_raster_to_page_format_unit] OK");
		else
			$display("[mono_raster_to_page_format_unit] ERROR");
		$finish;
	end

endmodule

### mono_raster_to_page_format_unit.f
hw/rtl/mrpf_pkg.sv
hw/rtl/mrpf_if.sv
hw/rtl/mrpf_ram.sv
hw/rtl/mrpf_front.sv
hw/rtl/mrpf_queue.sv
hw/rtl/mrpf_back.sv
hw/rtl/mono_raster_to_page_format_unit.sv
bench/tb_top.sv
